@@ rtl/core/vrr_pkg.sv @@
package vrr_pkg;

    localparam int NUM_PROCS_DEF  = 16;
    localparam int BURST_BITS_DEF = 8;

    localparam int IDX_W   = 4;
    localparam int BURST_W = 8;
    localparam int TQ_W    = 4;
    localparam int CNT_W   = 5;
    localparam int EV_W    = 2;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [TQ_W-1:0] TQ_RESET = 4'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_QUANTUM = 2'd1;
    localparam logic [EV_W-1:0] EV_BURST   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_START,
        ST_W_PROC,
        ST_W_UPD,
        ST_D_POP,
        ST_D_DATA,
        ST_D_ALLOT,
        ST_R_RD,
        ST_R_UPD,
        ST_OUT
    } vrr_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

@@ rtl/core/vrr_fifo.sv @@
module vrr_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4,
    parameter int CW    = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrr_pkg::q_ctrl_t     ctrl,
    input  logic [WIDTH-1:0]     push_data,
    output logic [WIDTH-1:0]     rdata,
    output logic [CW-1:0]        count
);
    import vrr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] rdata_reg;
    logic [CW:0]      tail_sum;
    logic [AW-1:0]    tail;
    logic             push_ok;

    assign push_ok  = ctrl.push && (count_reg < CW'(DEPTH));
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail     = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                   : AW'(tail_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_ok && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail] <= push_data;
        end
        if (ctrl.pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign rdata = rdata_reg;
    assign count = count_reg;

endmodule

@@ rtl/core/virtual_round_robin_scheduler_top.sv @@
// Load word: taken with no result.
// Tick word: gives one result once the wait queue has been walked; the walk reads and
// writes back each wait-queue entry on the process-table memory port.
// A new word is taken once the previous tick has reached the output register.
// Reset (async, active low) empties all queues and idles the CPU; the process
// table is not cleared, entries are written by a load before any use.
module virtual_round_robin_scheduler_top #(
    parameter int NUM_PROCS  = vrr_pkg::NUM_PROCS_DEF,
    parameter int BURST_BITS = vrr_pkg::BURST_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // proc_index[3:0], cpu_burst[11:4], io_burst[19:12], zero[23:20]
    input  logic [vrr_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // running_proc[3:0], cpu_idle[4], tick_event[6:5], ready_count[11:7],
    // aux_count[16:12], wait_count[21:17], zero[23:22]
    output logic [vrr_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_wen,
    input  logic [vrr_pkg::TQ_W-1:0]      cfg_wdata
);
    import vrr_pkg::*;

    localparam int PW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam int BB = BURST_BITS;
    localparam int MW = 4 * BB + TQ_W;

    // process table
    logic [MW-1:0] proc_mem [NUM_PROCS];
    logic          mem_we, mem_re;
    logic [PW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata_reg;
    logic [BB-1:0] rd_cb, rd_ib, rd_cl, rd_il;
    logic [TQ_W-1:0] rd_lq;

    assign rd_cb = mem_rdata_reg[BB-1:0];
    assign rd_ib = mem_rdata_reg[2*BB-1:BB];
    assign rd_cl = mem_rdata_reg[3*BB-1:2*BB];
    assign rd_il = mem_rdata_reg[4*BB-1:3*BB];
    assign rd_lq = mem_rdata_reg[MW-1:4*BB];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            proc_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= proc_mem[mem_raddr];
        end
    end

    // queues
    q_ctrl_t       rq_ctrl, aq_ctrl, wq_ctrl;
    logic [PW-1:0] rq_data, aq_data, wq_data;
    logic [PW-1:0] rq_rdata, aq_rdata, wq_rdata;
    logic [CW-1:0] rq_count, aq_count, wq_count;

    vrr_fifo #(.DEPTH(NUM_PROCS), .WIDTH(PW), .CW(CW)) u_ready (
        .clk(clk), .rst_n(rst_n), .ctrl(rq_ctrl), .push_data(rq_data),
        .rdata(rq_rdata), .count(rq_count)
    );
    vrr_fifo #(.DEPTH(NUM_PROCS), .WIDTH(PW), .CW(CW)) u_aux (
        .clk(clk), .rst_n(rst_n), .ctrl(aq_ctrl), .push_data(aq_data),
        .rdata(aq_rdata), .count(aq_count)
    );
    vrr_fifo #(.DEPTH(NUM_PROCS), .WIDTH(PW), .CW(CW)) u_wait (
        .clk(clk), .rst_n(rst_n), .ctrl(wq_ctrl), .push_data(wq_data),
        .rdata(wq_rdata), .count(wq_count)
    );

    // control registers
    vrr_state_t      state_reg, state_next;
    logic [TQ_W-1:0] tq_reg;
    logic [PW-1:0]   cur_reg, cur_next;
    logic            busy_reg, busy_next;
    logic [TQ_W-1:0] used_reg, used_next;
    logic [TQ_W-1:0] allot_reg, allot_next;
    logic [CW-1:0]   left_reg, left_next;
    logic [PW-1:0]   p_reg, p_next;
    logic            src_aux_reg, src_aux_next;
    logic            second_reg, second_next;
    logic [EV_W-1:0] event_reg, event_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic            s_fire, out_free;
    logic [IDX_W-1:0] ld_idx;
    logic [BB-1:0]   ld_cb, ld_ib;
    logic            ld_ok;
    logic [BB-1:0]   cl_dec, il_new;
    logic [TQ_W-1:0] used_inc, lq_new;
    logic            r_burst_end, r_quantum_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ld_idx = s_tdata[3:0];
    assign ld_cb  = (BB'(s_tdata[11:4]) == '0) ? BB'(1) : BB'(s_tdata[11:4]);
    assign ld_ib  = (BB'(s_tdata[19:12]) == '0) ? BB'(1) : BB'(s_tdata[19:12]);
    assign ld_ok  = (32'(ld_idx) < NUM_PROCS);

    assign cl_dec        = (rd_cl != '0) ? rd_cl - 1'b1 : rd_cl;
    assign used_inc      = used_reg + 1'b1;
    assign r_burst_end   = (cl_dec == '0);
    assign r_quantum_end = (used_inc >= allot_reg);
    assign lq_new        = (used_inc < allot_reg) ? allot_reg - used_inc : '0;
    assign il_new        = (rd_il <= BB'(1)) ? '0 : rd_il - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && s_tuser == CMD_TICK)
                begin
                    state_next = ST_W_START;
                end
            end
            ST_W_START:
            begin
                if (wq_count != '0)
                begin
                    state_next = ST_W_PROC;
                end
                else
                begin
                    state_next = busy_reg ? ST_R_RD : ST_D_POP;
                end
            end
            ST_W_PROC:
            begin
                state_next = ST_W_UPD;
            end
            ST_W_UPD:
            begin
                if (left_reg != '0)
                begin
                    state_next = ST_W_PROC;
                end
                else
                begin
                    state_next = busy_reg ? ST_R_RD : ST_D_POP;
                end
            end
            ST_D_POP:
            begin
                if (aq_count != '0 || rq_count != '0)
                begin
                    state_next = ST_D_DATA;
                end
                else
                begin
                    state_next = second_reg ? ST_OUT : ST_R_RD;
                end
            end
            ST_D_DATA:
            begin
                if (src_aux_reg)
                begin
                    state_next = ST_D_ALLOT;
                end
                else
                begin
                    state_next = second_reg ? ST_OUT : ST_R_RD;
                end
            end
            ST_D_ALLOT:
            begin
                state_next = second_reg ? ST_OUT : ST_R_RD;
            end
            ST_R_RD:
            begin
                state_next = busy_reg ? ST_R_UPD : ST_OUT;
            end
            ST_R_UPD:
            begin
                state_next = (r_burst_end || r_quantum_end) ? ST_D_POP : ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and queue control
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = mem_rdata_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        rq_ctrl       = '0;
        aq_ctrl       = '0;
        wq_ctrl       = '0;
        rq_data       = p_reg;
        aq_data       = p_reg;
        wq_data       = p_reg;
        cur_next      = cur_reg;
        busy_next     = busy_reg;
        used_next     = used_reg;
        allot_next    = allot_reg;
        left_next     = left_reg;
        p_next        = p_reg;
        src_aux_next  = src_aux_reg;
        second_next   = second_reg;
        event_next    = event_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && s_tuser == CMD_LOAD && ld_ok)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = PW'(ld_idx);
                    mem_wdata     = {{TQ_W{1'b0}}, ld_ib, ld_cb, ld_ib, ld_cb};
                    rq_ctrl.push  = 1'b1;
                    rq_data       = PW'(ld_idx);
                end
                if (s_fire && s_tuser == CMD_TICK)
                begin
                    event_next  = EV_NONE;
                    second_next = 1'b0;
                end
            end
            ST_W_START:
            begin
                if (wq_count != '0)
                begin
                    wq_ctrl.pop = 1'b1;
                    left_next   = wq_count - 1'b1;
                end
            end
            ST_W_PROC:
            begin
                mem_re    = 1'b1;
                mem_raddr = wq_rdata;
                p_next    = wq_rdata;
            end
            ST_W_UPD:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = {rd_lq, il_new, rd_cl, rd_ib, rd_cb};
                if (rd_il <= BB'(1))
                begin
                    if (rd_lq != '0)
                    begin
                        aq_ctrl.push = 1'b1;
                    end
                    else
                    begin
                        rq_ctrl.push = 1'b1;
                    end
                end
                else
                begin
                    wq_ctrl.push = 1'b1;
                end
                // next entry is read while this one is written back
                if (left_reg != '0)
                begin
                    wq_ctrl.pop = 1'b1;
                    left_next   = left_reg - 1'b1;
                end
            end
            ST_D_POP:
            begin
                used_next = '0;
                if (aq_count != '0)
                begin
                    aq_ctrl.pop  = 1'b1;
                    src_aux_next = 1'b1;
                end
                else if (rq_count != '0)
                begin
                    rq_ctrl.pop  = 1'b1;
                    src_aux_next = 1'b0;
                end
                else
                begin
                    busy_next  = 1'b0;
                    cur_next   = '0;
                    allot_next = '0;
                end
            end
            ST_D_DATA:
            begin
                cur_next  = src_aux_reg ? aq_rdata : rq_rdata;
                busy_next = 1'b1;
                if (src_aux_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = aq_rdata;
                end
                else
                begin
                    allot_next = (tq_reg == '0) ? TQ_W'(1) : tq_reg;
                end
            end
            ST_D_ALLOT:
            begin
                allot_next = (rd_lq == '0) ? TQ_W'(1) : rd_lq;
            end
            ST_R_RD:
            begin
                if (busy_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg;
                end
            end
            ST_R_UPD:
            begin
                used_next = used_inc;
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                wq_data   = cur_reg;
                rq_data   = cur_reg;
                if (r_burst_end)
                begin
                    mem_wdata    = {lq_new, rd_ib, rd_cb, rd_ib, rd_cb};
                    wq_ctrl.push = 1'b1;
                    event_next   = EV_BURST;
                    second_next  = 1'b1;
                end
                else if (r_quantum_end)
                begin
                    mem_wdata    = {{TQ_W{1'b0}}, rd_il, cl_dec, rd_ib, rd_cb};
                    rq_ctrl.push = 1'b1;
                    event_next   = EV_QUANTUM;
                    second_next  = 1'b1;
                end
                else
                begin
                    mem_wdata = {rd_lq, rd_il, cl_dec, rd_ib, rd_cb};
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00,
                                     CNT_W'(wq_count), CNT_W'(aq_count), CNT_W'(rq_count),
                                     event_reg, !busy_reg,
                                     busy_reg ? IDX_W'(cur_reg) : IDX_W'(0)};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tq_reg       <= TQ_RESET;
            cur_reg      <= '0;
            busy_reg     <= 1'b0;
            used_reg     <= '0;
            allot_reg    <= '0;
            left_reg     <= '0;
            src_aux_reg  <= 1'b0;
            second_reg   <= 1'b0;
            event_reg    <= EV_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_wen)
            begin
                tq_reg <= cfg_wdata;
            end
            cur_reg      <= cur_next;
            busy_reg     <= busy_next;
            used_reg     <= used_next;
            allot_reg    <= allot_next;
            left_reg     <= left_next;
            src_aux_reg  <= src_aux_next;
            second_reg   <= second_next;
            event_reg    <= event_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_idle_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cur_reg == '0)
        else $error("idle CPU holds a process number");

    a_out_idle_proc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0)
        else $error("idle result carries a process number");

    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count <= CW'(NUM_PROCS) && aq_count <= CW'(NUM_PROCS) &&
        wq_count <= CW'(NUM_PROCS))
        else $error("queue count beyond depth");

    a_busy_allot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_R_UPD |-> allot_reg != '0)
        else $error("running process without allotment");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import vrr_pkg::*;

    localparam int NPROC = 16;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] proc_idx;
        logic [7:0]       cpu_len;
        logic [7:0]       io_len;
    } sched_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] running;
        logic             idle;
        logic [EV_W-1:0]  event_code;
        logic [CNT_W-1:0] n_ready;
        logic [CNT_W-1:0] n_aux;
        logic [CNT_W-1:0] n_wait;
    } tick_status_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_wen;
    logic [TQ_W-1:0] cfg_wdata;

    virtual_round_robin_scheduler_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    // scheduler shadow state
    logic [3:0] rdy_q[$];
    logic [3:0] aux_q[$];
    logic [3:0] wait_q[$];
    logic [7:0] cpu_tbl[NPROC];
    logic [7:0] io_tbl[NPROC];
    logic [7:0] cpu_rem[NPROC];
    logic [7:0] io_rem[NPROC];
    logic [3:0] quantum_left[NPROC];
    logic [3:0] cur_proc;
    logic       busy;
    logic [3:0] used;
    logic [3:0] allot;
    logic [3:0] quantum;

    sched_word_t  pending_words[$];
    tick_status_t expected_status[$];

    int  mismatches = 0;
    bit  idle_bursts_on = 1;
    bit  sink_hold = 0;
    int  src_gap = 0;
    int  sink_gap = 0;

    task automatic push_q(ref logic [3:0] q[$], input logic [3:0] p);
        if (q.size() < NPROC)
            q.push_back(p);
    endtask

    task automatic pick_next();
        if (aux_q.size() > 0) begin
            cur_proc = aux_q.pop_front();
            allot = (quantum_left[cur_proc] == 0) ? 4'd1 : quantum_left[cur_proc];
            busy = 1;
        end else if (rdy_q.size() > 0) begin
            cur_proc = rdy_q.pop_front();
            allot = (quantum == 0) ? 4'd1 : quantum;
            busy = 1;
        end else begin
            busy = 0;
            cur_proc = 0;
            allot = 0;
        end
        used = 0;
    endtask

    task automatic schedule_word(input sched_word_t w);
        tick_status_t r;
        logic [7:0] cb;
        logic [7:0] ib;
        logic [3:0] p;
        logic [EV_W-1:0] ev;
        int n;
        if (w.cmd == CMD_LOAD) begin
            p = w.proc_idx;
            cb = (w.cpu_len == 0) ? 8'd1 : w.cpu_len;
            ib = (w.io_len == 0) ? 8'd1 : w.io_len;
            cpu_tbl[p] = cb;
            io_tbl[p] = ib;
            cpu_rem[p] = cb;
            io_rem[p] = ib;
            quantum_left[p] = 0;
            push_q(rdy_q, p);
            return;
        end
        ev = EV_NONE;
        n = wait_q.size();
        for (int i = 0; i < n; i++) begin
            p = wait_q.pop_front();
            if (io_rem[p] <= 1) begin
                io_rem[p] = 0;
                if (quantum_left[p] != 0)
                    push_q(aux_q, p);
                else
                    push_q(rdy_q, p);
            end else begin
                io_rem[p] = io_rem[p] - 8'd1;
                push_q(wait_q, p);
            end
        end
        if (!busy)
            pick_next();
        if (busy) begin
            p = cur_proc;
            if (cpu_rem[p] > 0)
                cpu_rem[p] = cpu_rem[p] - 8'd1;
            used = used + 4'd1;
            if (cpu_rem[p] == 0) begin
                quantum_left[p] = (used < allot) ? allot - used : 4'd0;
                cpu_rem[p] = cpu_tbl[p];
                io_rem[p] = io_tbl[p];
                push_q(wait_q, p);
                ev = EV_BURST;
                pick_next();
            end else if (used >= allot) begin
                quantum_left[p] = 0;
                push_q(rdy_q, p);
                ev = EV_QUANTUM;
                pick_next();
            end
        end
        r.running = busy ? cur_proc : 4'd0;
        r.idle = !busy;
        r.event_code = ev;
        r.n_ready = CNT_W'(rdy_q.size());
        r.n_aux = CNT_W'(aux_q.size());
        r.n_wait = CNT_W'(wait_q.size());
        expected_status.push_back(r);
    endtask

    function automatic sched_word_t load_word(int p, int cb, int ib);
        sched_word_t w;
        w.cmd = CMD_LOAD;
        w.proc_idx = IDX_W'(p);
        w.cpu_len = 8'(cb);
        w.io_len = 8'(ib);
        return w;
    endfunction

    function automatic sched_word_t tick_word();
        sched_word_t w;
        w = '0;
        w.cmd = CMD_TICK;
        w.proc_idx = IDX_W'($urandom);
        w.cpu_len = 8'($urandom);
        w.io_len = 8'($urandom);
        return w;
    endfunction

    // bursts mostly short so processes cycle through all queues
    function automatic int short_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 6);
        else if (r < 9)
            return $urandom_range(7, 30);
        return $urandom_range(0, 255);
    endfunction

    function automatic sched_word_t random_word();
        if ($urandom_range(0, 3) == 0)
            return load_word($urandom_range(0, 15), short_len(), short_len());
        return tick_word();
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= 0;
            src_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                schedule_word(pending_words.pop_front());
            end
            if ((s_tvalid && !s_tready)) begin
                // hold current word
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 0;
            end else if (pending_words.size() > 0) begin
                if (idle_bursts_on && s_tvalid && $urandom_range(0, 5) == 0) begin
                    s_tvalid <= 0;
                    src_gap <= $urandom_range(0, 3);
                end else begin
                    sched_word_t w;
                    w = pending_words[0];
                    s_tvalid <= 1;
                    s_tuser <= w.cmd;
                    s_tdata <= {4'b0, w.io_len, w.cpu_len, w.proc_idx};
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tick_status_t got;
                tick_status_t exp_r;
                got.running = m_tdata[3:0];
                got.idle = m_tdata[4];
                got.event_code = m_tdata[6:5];
                got.n_ready = m_tdata[11:7];
                got.n_aux = m_tdata[16:12];
                got.n_wait = m_tdata[21:17];
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status word %h", m_tdata);
                end else begin
                    exp_r = expected_status.pop_front();
                    if (got !== exp_r || m_tdata[23:22] !== 2'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"status mismatch: exp run=%0d idle=%0d ev=%0d ",
                                      "rdy=%0d aux=%0d wait=%0d, got run=%0d idle=%0d ",
                                      "ev=%0d rdy=%0d aux=%0d wait=%0d"},
                                exp_r.running, exp_r.idle, exp_r.event_code, exp_r.n_ready,
                                exp_r.n_aux, exp_r.n_wait, got.running, got.idle,
                                got.event_code, got.n_ready, got.n_aux, got.n_wait);
                    end
                end
            end
            if (sink_hold) begin
                m_tready <= 0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 0;
            end else if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                sink_gap <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_status.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [3:0] v);
        @(posedge clk);
        cfg_wen <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 0;
        quantum = v;
    endtask

    initial
    begin
        rst_n = 0;
        cfg_wen = 0;
        cfg_wdata = '0;
        quantum = TQ_RESET;
        busy = 0;
        cur_proc = 0;
        used = 0;
        allot = 0;
        for (int i = 0; i < NPROC; i++)
            quantum_left[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: idle ticks at reset quantum, extremes, reload, quantum vs burst end
        pending_words.push_back(tick_word());
        pending_words.push_back(load_word(0, 0, 0));
        pending_words.push_back(load_word(15, 255, 255));
        pending_words.push_back(load_word(5, 3, 2));
        pending_words.push_back(load_word(5, 2, 1));
        pending_words.push_back(load_word(10, 170, 85));
        pending_words.push_back(load_word(6, 85, 170));
        for (int i = 0; i < 14; i++)
            pending_words.push_back(tick_word());
        wait_drained();

        // zero quantum, then fill ready queue past its depth
        write_quantum(0);
        for (int i = 0; i < 18; i++)
            pending_words.push_back(load_word(i % 16, 1, $urandom_range(1, 3)));
        for (int i = 0; i < 6; i++)
            pending_words.push_back(tick_word());
        wait_drained();

        // long receiver stall while the sender keeps offering
        sink_hold = 1;
        for (int i = 0; i < 20; i++)
            pending_words.push_back(tick_word());
        repeat (300) @(posedge clk);
        sink_hold = 0;
        wait_drained();

        write_quantum(15);
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 200; i++)
                pending_words.push_back(random_word());
            if (ph == 5)
                idle_bursts_on = 0;
            wait_drained();
            write_quantum(ph == 4 ? 4'd1 : 4'($urandom_range(0, 15)));
        end

        if (mismatches == 0 && expected_status.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
